// ===== src/oas_pkg.sv =====
// oas_pkg: shared types, constants and helpers for the obstacle avoidance sequencer
// no dependencies; imported by every module of the block

package oas_pkg;

  // sequence mode codes
  localparam logic [3:0] MODE_DETECT      = 4'd0;
  localparam logic [3:0] MODE_TURN_AWAY   = 4'd1;
  localparam logic [3:0] MODE_FWD_AVOID   = 4'd2;
  localparam logic [3:0] MODE_CORRECT     = 4'd3;
  localparam logic [3:0] MODE_UNDO        = 4'd4;
  localparam logic [3:0] MODE_FWD_CORRECT = 4'd5;
  localparam logic [3:0] MODE_RETURN_TURN = 4'd6;
  localparam logic [3:0] MODE_RETURN_UNDO = 4'd7;
  localparam logic [3:0] MODE_RETURN_FWD  = 4'd8;

  // register indexes
  localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_BASE_SPEED     = 3'd2;
  localparam logic [2:0] REG_TURN_RATIO     = 3'd3;
  localparam logic [2:0] REG_FWD_AVOID      = 3'd4;
  localparam logic [2:0] REG_MAX_CORRECT    = 3'd5;
  localparam logic [2:0] REG_CORRECT_FWD    = 3'd6;
  localparam logic [2:0] REG_RETURN_FWD     = 3'd7;

  localparam int unsigned PADDR_W = 5;

  // fixed phase lengths in ms
  localparam logic [15:0] TURN_AWAY_EXTRA_MS = 16'd50;
  localparam logic [15:0] UNDO_TURN_MS       = 16'd600;
  localparam logic [15:0] MAX_RETURN_TURN_MS = 16'd1000;
  localparam logic [15:0] RETURN_UNDO_MS     = 16'd300;

  localparam logic signed [9:0] POWER_MAX = 10'sd100;
  localparam logic signed [9:0] POWER_MIN = -10'sd100;

  typedef struct packed {
    logic [7:0] left_distance;
    logic [7:0] right_distance;
    logic [7:0] elapsed_ms;
    logic       on_line;
  } tick_t;

  typedef struct packed {
    logic              active;
    logic signed [7:0] left_power;
    logic signed [7:0] right_power;
    logic [3:0]        mode;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  low_threshold;
    logic [7:0]  high_threshold;
    logic [5:0]  base_speed;
    logic [8:0]  turn_ratio_q8;
    logic [15:0] forward_avoid_ms;
    logic [15:0] max_turn_correction_ms;
    logic [15:0] correct_forward_ms;
    logic [15:0] return_forward_ms;
  } cfg_t;

  // saturate a wide power to the signed percent range
  function automatic logic signed [7:0] clamp_power(input logic signed [9:0] v);
    logic signed [9:0] c;
    if (v > POWER_MAX) begin
      c = POWER_MAX;
    end else if (v < POWER_MIN) begin
      c = POWER_MIN;
    end else begin
      c = v;
    end
    return c[7:0];
  endfunction

endpackage

// ===== src/oas_regs.sv =====
// oas_regs: APB-style configuration registers of the sequencer
// depends on oas_pkg for the register indexes and the cfg_t struct

module oas_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [oas_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output oas_pkg::cfg_t                cfg
);
  import oas_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold          <= 8'd10;
      cfg.high_threshold         <= 8'd30;
      cfg.base_speed             <= 6'd25;
      cfg.turn_ratio_q8          <= 9'd179;
      cfg.forward_avoid_ms       <= 16'd3000;
      cfg.max_turn_correction_ms <= 16'd1500;
      cfg.correct_forward_ms     <= 16'd3000;
      cfg.return_forward_ms      <= 16'd1500;
    end else if (wr) begin
      unique case (idx)
        REG_LOW_THRESHOLD:  cfg.low_threshold          <= pwdata[7:0];
        REG_HIGH_THRESHOLD: cfg.high_threshold         <= pwdata[7:0];
        REG_BASE_SPEED:     cfg.base_speed             <= pwdata[5:0];
        REG_TURN_RATIO:     cfg.turn_ratio_q8          <= pwdata[8:0];
        REG_FWD_AVOID:      cfg.forward_avoid_ms       <= pwdata[15:0];
        REG_MAX_CORRECT:    cfg.max_turn_correction_ms <= pwdata[15:0];
        REG_CORRECT_FWD:    cfg.correct_forward_ms     <= pwdata[15:0];
        REG_RETURN_FWD:     cfg.return_forward_ms      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_LOW_THRESHOLD:  prdata = {24'd0, cfg.low_threshold};
      REG_HIGH_THRESHOLD: prdata = {24'd0, cfg.high_threshold};
      REG_BASE_SPEED:     prdata = {26'd0, cfg.base_speed};
      REG_TURN_RATIO:     prdata = {23'd0, cfg.turn_ratio_q8};
      REG_FWD_AVOID:      prdata = {16'd0, cfg.forward_avoid_ms};
      REG_MAX_CORRECT:    prdata = {16'd0, cfg.max_turn_correction_ms};
      REG_CORRECT_FWD:    prdata = {16'd0, cfg.correct_forward_ms};
      REG_RETURN_FWD:     prdata = {16'd0, cfg.return_forward_ms};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/oas_step.sv =====
// oas_step: sequence state registers and the per-beat mode update
// depends on oas_pkg for mode codes, structs and clamp_power

module oas_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  oas_pkg::cfg_t  cfg,
  input  oas_pkg::tick_t tick,
  output oas_pkg::cmd_t  result
);
  import oas_pkg::*;

  logic [3:0]        mode_reg, mode_reg_next;
  logic              turn_dir, turn_dir_next;
  logic [15:0]       phase_timer, phase_timer_next;
  logic signed [7:0] last_left, last_left_next;
  logic signed [7:0] last_right, last_right_next;
  logic              active_reg, active_reg_next;

  logic [16:0]       t_sum;
  logic [15:0]       t_sat;
  logic [6:0]        d_speed;
  logic [15:0]       rt_prod;
  logic signed [9:0] d_s, r_s;
  logic signed [9:0] away_l, back_l;
  logic [7:0]        watch_dist;
  logic              drv;
  logic signed [9:0] drv_l, drv_r;

  // timer advance with saturation, drive powers
  assign t_sum      = {1'b0, phase_timer} + {9'd0, tick.elapsed_ms};
  assign t_sat      = t_sum[16] ? 16'hFFFF : t_sum[15:0];
  assign d_speed    = {cfg.base_speed, 1'b0};
  assign rt_prod    = {9'd0, d_speed} * {7'd0, cfg.turn_ratio_q8};
  assign d_s        = $signed({3'd0, d_speed});
  assign r_s        = $signed({2'd0, rt_prod[15:8]});
  assign away_l     = turn_dir ? d_s : -d_s;
  assign back_l     = turn_dir ? -r_s : r_s;
  assign watch_dist = turn_dir ? tick.right_distance : tick.left_distance;

  // mode update
  always_comb begin
    mode_reg_next    = mode_reg;
    turn_dir_next    = turn_dir;
    phase_timer_next = t_sat;
    drv              = 1'b0;
    drv_l            = d_s;
    drv_r            = d_s;
    unique case (mode_reg)
      MODE_TURN_AWAY: begin
        if (watch_dist < cfg.high_threshold || t_sat < TURN_AWAY_EXTRA_MS) begin
          drv   = 1'b1;
          drv_l = away_l;
          drv_r = -away_l;
          if (watch_dist < cfg.high_threshold) phase_timer_next = 16'd0;
        end else begin
          mode_reg_next    = MODE_FWD_AVOID;
          phase_timer_next = 16'd0;
        end
      end
      MODE_FWD_AVOID: begin
        if (t_sat < cfg.forward_avoid_ms) begin
          drv = 1'b1;
        end else begin
          mode_reg_next    = MODE_CORRECT;
          phase_timer_next = 16'd0;
        end
      end
      MODE_CORRECT: begin
        if (watch_dist > cfg.high_threshold && t_sat < cfg.max_turn_correction_ms) begin
          drv   = 1'b1;
          drv_l = back_l;
          drv_r = -back_l;
        end else begin
          mode_reg_next    = MODE_UNDO;
          phase_timer_next = 16'd0;
        end
      end
      MODE_UNDO: begin
        if (t_sat < UNDO_TURN_MS) begin
          drv   = 1'b1;
          drv_l = away_l;
          drv_r = -away_l;
        end else begin
          mode_reg_next    = MODE_FWD_CORRECT;
          phase_timer_next = 16'd0;
        end
      end
      MODE_FWD_CORRECT: begin
        if (t_sat < cfg.correct_forward_ms) begin
          drv = 1'b1;
        end else begin
          mode_reg_next    = MODE_RETURN_TURN;
          phase_timer_next = 16'd0;
        end
      end
      MODE_RETURN_TURN: begin
        if (watch_dist > cfg.high_threshold && t_sat < MAX_RETURN_TURN_MS) begin
          drv   = 1'b1;
          drv_l = back_l;
          drv_r = -back_l;
        end else begin
          mode_reg_next    = MODE_RETURN_UNDO;
          phase_timer_next = 16'd0;
        end
      end
      MODE_RETURN_UNDO: begin
        if (t_sat < RETURN_UNDO_MS) begin
          drv   = 1'b1;
          drv_l = away_l;
          drv_r = -away_l;
        end else begin
          mode_reg_next    = MODE_RETURN_FWD;
          phase_timer_next = 16'd0;
        end
      end
      MODE_RETURN_FWD: begin
        if (t_sat > {1'b0, cfg.return_forward_ms[15:1]} && tick.on_line) begin
          mode_reg_next = MODE_DETECT;
        end else if (t_sat < cfg.return_forward_ms) begin
          drv = 1'b1;
        end else begin
          mode_reg_next = MODE_DETECT;
        end
      end
      default: begin
        // detect, and unused codes behave the same
        mode_reg_next = MODE_DETECT;
        if (tick.left_distance < cfg.low_threshold ||
            tick.right_distance < cfg.low_threshold) begin
          mode_reg_next = MODE_TURN_AWAY;
          turn_dir_next = !(tick.left_distance <= tick.right_distance);
        end
      end
    endcase
  end

  // command hold: detect clears, drive loads, mode change repeats
  always_comb begin
    last_left_next  = last_left;
    last_right_next = last_right;
    active_reg_next = active_reg;
    if (mode_reg == MODE_DETECT || mode_reg > MODE_RETURN_FWD) begin
      last_left_next  = 8'sd0;
      last_right_next = 8'sd0;
      active_reg_next = 1'b0;
    end else if (drv) begin
      last_left_next  = clamp_power(drv_l);
      last_right_next = clamp_power(drv_r);
      active_reg_next = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_DETECT;
      turn_dir    <= 1'b0;
      phase_timer <= 16'd0;
      last_left   <= 8'sd0;
      last_right  <= 8'sd0;
      active_reg  <= 1'b0;
    end else if (fire) begin
      mode_reg    <= mode_reg_next;
      turn_dir    <= turn_dir_next;
      phase_timer <= phase_timer_next;
      last_left   <= last_left_next;
      last_right  <= last_right_next;
      active_reg  <= active_reg_next;
    end
  end

  assign result.active      = active_reg_next;
  assign result.left_power  = last_left_next;
  assign result.right_power = last_right_next;
  assign result.mode        = mode_reg_next;

endmodule

// ===== src/obstacle_avoid_sequencer.sv =====
// obstacle_avoid_sequencer: top level with input and result registers around the step logic
// depends on oas_pkg, oas_regs and oas_step
//
// usage:
//   tick channel (tick_valid/tick_ready/tick) carries one sensor beat per control tick:
//   both sonar distances, the elapsed milliseconds and the line flag.
//   cmd channel (cmd_valid/cmd_ready/cmd) returns one beat per tick: active flag,
//   left and right motor power and the mode after the update.
//   the APB-style port sets thresholds, speeds and phase lengths; write it only
//   while no beat is in flight.
// order: a tick beat lands in the input register, the mode update then runs from
//   it into the result register and raises cmd_valid; while the result register
//   is stalled the update waits, and the cmd beat leaves when cmd_ready is high.
// throughput: one beat per cycle while cmd_ready stays high; the whole update is one
//   pass of logic between the input register and the result register, with the
//   sequence state written back in the same cycle.
// reset: synchronous; mode goes to detect, timer and powers to zero, config to
//   defaults, both channels empty.
// stall: while cmd_ready is low the result register holds; the input register
//   still takes one more tick beat, then tick_ready drops until the result moves.

module obstacle_avoid_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tick_valid,
  output logic                         tick_ready,
  input  oas_pkg::tick_t               tick,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output oas_pkg::cmd_t                cmd,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [oas_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import oas_pkg::*;

  cfg_t  cfg;
  tick_t tick_q;
  logic  tick_full;
  logic  fire;
  cmd_t  result;

  oas_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the step runs when a beat waits and the result register can take it
  assign fire       = tick_full && (!cmd_valid || cmd_ready);
  assign tick_ready = !tick_full || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_full <= 1'b0;
    end else if (tick_ready) begin
      tick_full <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      tick_q <= tick;
    end
  end

  oas_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .cfg    (cfg),
    .tick   (tick_q),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (fire) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cmd <= result;
    end
  end

endmodule

// ===== verif/obstacle_avoid_sequencer_tb.sv =====
`timescale 1ns / 1ps
// obstacle_avoid_sequencer_tb: self-checking bench for the obstacle avoidance sequencer
// drives tick beats and register writes, predicts every motor command beat and checks it
// depends on oas_pkg and obstacle_avoid_sequencer

module obstacle_avoid_sequencer_tb;
  import oas_pkg::*;

  localparam int unsigned TICKS_PLANNED = 1700;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned HOLD_CYCLES   = 80;

  // predicts the motor command beat for every accepted tick
  class motor_cmd_board;
    cfg_t              cfg;
    logic [3:0]        mode_q;
    logic              dir_q;
    int unsigned       timer_q;
    logic signed [7:0] left_q;
    logic signed [7:0] right_q;
    logic              active_q;
    cmd_t              cmds_due[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       sweeps;

    function new();
      cfg = '{10, 30, 25, 179, 3000, 1500, 3000, 1500};
      mode_q = MODE_DETECT;
      dir_q = 1'b0;
      timer_q = 0;
      left_q = '0;
      right_q = '0;
      active_q = 1'b0;
      errors = 0;
      checked = 0;
      sweeps = 0;
    endfunction

    function void apply_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_LOW_THRESHOLD:  cfg.low_threshold = val[7:0];
        REG_HIGH_THRESHOLD: cfg.high_threshold = val[7:0];
        REG_BASE_SPEED:     cfg.base_speed = val[5:0];
        REG_TURN_RATIO:     cfg.turn_ratio_q8 = val[8:0];
        REG_FWD_AVOID:      cfg.forward_avoid_ms = val[15:0];
        REG_MAX_CORRECT:    cfg.max_turn_correction_ms = val[15:0];
        REG_CORRECT_FWD:    cfg.correct_forward_ms = val[15:0];
        REG_RETURN_FWD:     cfg.return_forward_ms = val[15:0];
        default: ;
      endcase
    endfunction

    // saturate to the signed percent range
    function logic signed [7:0] clip(int v);
      if (v > 100) return 8'sd100;
      if (v < -100) return -8'sd100;
      return v[7:0];
    endfunction

    function void set_powers(int l, int r);
      left_q = clip(l);
      right_q = clip(r);
      active_q = 1'b1;
    endfunction

    function void predict_tick(tick_t tk);
      int unsigned t;
      int          d;
      int          rt;
      int          s;
      logic [7:0]  watch_dist;
      t = timer_q + tk.elapsed_ms;
      if (t > 65535) t = 65535;
      d = 2 * int'(cfg.base_speed);
      rt = (d * int'(cfg.turn_ratio_q8)) >>> 8;
      s = dir_q ? -1 : 1;
      watch_dist = dir_q ? tk.right_distance : tk.left_distance;
      case (mode_q)
        MODE_TURN_AWAY: begin
          if (watch_dist < cfg.high_threshold || t < TURN_AWAY_EXTRA_MS) begin
            set_powers(-s * d, s * d);
            if (watch_dist < cfg.high_threshold) t = 0;
          end else begin
            mode_q = MODE_FWD_AVOID;
            t = 0;
          end
        end
        MODE_FWD_AVOID: begin
          if (t < cfg.forward_avoid_ms) begin
            set_powers(d, d);
          end else begin
            mode_q = MODE_CORRECT;
            t = 0;
          end
        end
        MODE_CORRECT: begin
          if (watch_dist > cfg.high_threshold && t < cfg.max_turn_correction_ms) begin
            set_powers(s * rt, -s * rt);
          end else begin
            mode_q = MODE_UNDO;
            t = 0;
          end
        end
        MODE_UNDO: begin
          if (t < UNDO_TURN_MS) begin
            set_powers(-s * d, s * d);
          end else begin
            mode_q = MODE_FWD_CORRECT;
            t = 0;
          end
        end
        MODE_FWD_CORRECT: begin
          if (t < cfg.correct_forward_ms) begin
            set_powers(d, d);
          end else begin
            mode_q = MODE_RETURN_TURN;
            t = 0;
          end
        end
        MODE_RETURN_TURN: begin
          if (watch_dist > cfg.high_threshold && t < MAX_RETURN_TURN_MS) begin
            set_powers(s * rt, -s * rt);
          end else begin
            mode_q = MODE_RETURN_UNDO;
            t = 0;
          end
        end
        MODE_RETURN_UNDO: begin
          if (t < RETURN_UNDO_MS) begin
            set_powers(-s * d, s * d);
          end else begin
            mode_q = MODE_RETURN_FWD;
            t = 0;
          end
        end
        MODE_RETURN_FWD: begin
          // line seen after half the return time ends the sweep early
          if (t > (cfg.return_forward_ms >> 1) && tk.on_line) begin
            mode_q = MODE_DETECT;
            sweeps++;
          end else if (t < cfg.return_forward_ms) begin
            set_powers(d, d);
          end else begin
            mode_q = MODE_DETECT;
            sweeps++;
          end
        end
        default: begin
          mode_q = MODE_DETECT;
          if (tk.left_distance < cfg.low_threshold || tk.right_distance < cfg.low_threshold) begin
            mode_q = MODE_TURN_AWAY;
            dir_q = (tk.left_distance <= tk.right_distance) ? 1'b0 : 1'b1;
          end
          active_q = 1'b0;
          left_q = '0;
          right_q = '0;
        end
      endcase
      timer_q = t;
      cmds_due.push_back('{active_q, left_q, right_q, mode_q});
    endfunction

    function void check_cmd(cmd_t got);
      cmd_t want;
      if (cmds_due.size() == 0) begin
        $error("cmd beat %h arrived with no tick outstanding", got);
        errors++;
        return;
      end
      want = cmds_due.pop_front();
      checked++;
      if (got.active !== want.active) begin
        $error("active: expected %0d, got %0d", want.active, got.active);
        errors++;
      end
      if (got.left_power !== want.left_power) begin
        $error("left_power: expected %0d, got %0d", want.left_power, got.left_power);
        errors++;
      end
      if (got.right_power !== want.right_power) begin
        $error("right_power: expected %0d, got %0d", want.right_power, got.right_power);
        errors++;
      end
      if (got.mode !== want.mode) begin
        $error("mode: expected %0d, got %0d", want.mode, got.mode);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return cmds_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 tick_valid = 1'b0;
  logic                 tick_ready;
  tick_t                tick = '0;
  logic                 cmd_valid;
  logic                 cmd_ready = 1'b0;
  cmd_t                 cmd;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  motor_cmd_board       sb;
  int unsigned          ticks_taken = 0;
  int unsigned          tx_idle_pct = 28;
  int unsigned          rx_idle_pct = 57;
  int unsigned          cycles = 0;
  bit                   held_off = 1'b0;

  obstacle_avoid_sequencer i_dut (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_ready (tick_ready),
    .tick       (tick),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("obstacle_avoid_sequencer_tb: FAIL");
      $finish;
    end
  end

  // check every cmd beat as it is taken
  always @(posedge clk) begin
    if (!rst && cmd_valid && cmd_ready) sb.check_cmd(cmd);
  end

  // cmd sink: random stalls, plus one long hold-off to back up the tick side
  initial begin : cmd_sink
    forever begin
      @(negedge clk);
      if (!held_off && ticks_taken >= 200) begin
        held_off = 1'b1;
        cmd_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      cmd_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // offer one tick beat, called at a falling edge and returns at one
  task automatic offer_tick(input tick_t t);
    if ($urandom_range(99) < tx_idle_pct) begin
      tick_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    tick <= t;
    tick_valid <= 1'b1;
    do @(posedge clk); while (!tick_ready);
    sb.predict_tick(t);
    ticks_taken++;
    // idling: sender light first, then receiver light, then none
    if (ticks_taken < TICKS_PLANNED / 3) begin
      tx_idle_pct = 28;
      rx_idle_pct = 57;
    end else if (ticks_taken < 2 * TICKS_PLANNED / 3) begin
      tx_idle_pct = 57;
      rx_idle_pct = 28;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    @(negedge clk);
  endtask

  // apb write: setup then access, then idle with psel low before returning
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.apply_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_setup(input cfg_t c);
    write_reg(REG_LOW_THRESHOLD, 32'(c.low_threshold));
    write_reg(REG_HIGH_THRESHOLD, 32'(c.high_threshold));
    write_reg(REG_BASE_SPEED, 32'(c.base_speed));
    write_reg(REG_TURN_RATIO, 32'(c.turn_ratio_q8));
    write_reg(REG_FWD_AVOID, 32'(c.forward_avoid_ms));
    write_reg(REG_MAX_CORRECT, 32'(c.max_turn_correction_ms));
    write_reg(REG_CORRECT_FWD, 32'(c.correct_forward_ms));
    write_reg(REG_RETURN_FWD, 32'(c.return_forward_ms));
  endtask

  // stop offering and wait for every cmd beat to come back
  task automatic drain();
    tick_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // directed sweep: the watched sonar opens or closes to pick each exit
  function automatic tick_t sweep_tick(input bit open);
    tick_t      t;
    logic [7:0] watched;
    t = '{8'd128, 8'd128, 8'd255, open};
    case (sb.mode_q)
      MODE_TURN_AWAY:                 watched = (sb.timer_q != 0) ? 8'd0 : 8'd255;
      MODE_CORRECT, MODE_RETURN_TURN: watched = open ? 8'd255 : 8'd0;
      default:                        watched = 8'd255;
    endcase
    if (sb.dir_q) t.right_distance = watched;
    else t.left_distance = watched;
    return t;
  endfunction

  // random tick, mostly shaped to push the sequence through its modes
  function automatic tick_t rand_tick();
    tick_t       t;
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    logic [7:0]  watched;
    bit          steer;
    t = tick_t'($bits(tick_t)'($urandom));
    if ($urandom_range(99) < 15) return t;
    lo = sb.cfg.low_threshold;
    hi = sb.cfg.high_threshold;
    steer = 1'b0;
    watched = 8'd0;
    // mostly long steps so timed modes move along
    roll = $urandom_range(9);
    if (roll < 5) t.elapsed_ms = 8'($urandom_range(255, 160));
    else if (roll == 9) t.elapsed_ms = 8'($urandom_range(15, 0));
    case (sb.mode_q)
      MODE_DETECT: begin
        if ($urandom_range(3) != 0 && lo != 0) begin
          if ($urandom_range(1)) t.left_distance = 8'($urandom_range(lo - 1, 0));
          else t.right_distance = 8'($urandom_range(lo - 1, 0));
        end else begin
          t.left_distance = 8'($urandom_range(255, lo));
          t.right_distance = 8'($urandom_range(255, lo));
        end
      end
      MODE_TURN_AWAY: begin
        steer = 1'b1;
        watched = ($urandom_range(9) < 3 && hi != 0) ? 8'($urandom_range(hi - 1, 0))
                                                      : 8'($urandom_range(255, hi));
      end
      MODE_CORRECT, MODE_RETURN_TURN: begin
        steer = 1'b1;
        watched = ($urandom_range(3) != 0 && hi != 255) ? 8'($urandom_range(255, hi + 1))
                                                         : 8'($urandom_range(hi, 0));
      end
      MODE_RETURN_FWD: t.on_line = ($urandom_range(3) == 0);
      default: ;
    endcase
    if (steer) begin
      if (sb.dir_q) t.right_distance = watched;
      else t.left_distance = watched;
    end
    return t;
  endfunction

  initial begin : stimulus
    cfg_t        setups [6];
    int unsigned burst [6];
    sb = new();
    // directed: short phases so both sweeps fit in a few ticks
    setups[0] = '{10, 30, 50, 256, 0, 300, 0, 1000};
    // power-on values
    setups[1] = '{10, 30, 25, 179, 3000, 1500, 3000, 1500};
    // tight phases, wide thresholds
    setups[2] = '{40, 60, 50, 256, 200, 400, 300, 500};
    // zero speed and timing, everything triggers
    setups[3] = '{255, 0, 0, 0, 0, 0, 0, 0};
    // power saturation and timer saturation
    setups[4] = '{128, 128, 63, 511, 65535, 65535, 100, 65535};
    setups[5] = '{20, 25, 37, 100, 1000, 700, 800, 2000};
    burst = '{0, 300, 350, 200, 500, 300};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_setup(setups[0]);
    // clear path with no elapsed time, then a left obstacle at full step
    offer_tick('{8'd255, 8'd255, 8'd0, 1'b0});
    offer_tick('{8'd0, 8'd255, 8'd255, 1'b1});
    while (sb.mode_q != MODE_DETECT) offer_tick(sweep_tick(1'b1));
    // right obstacle, closing turns; random part carries on from here
    offer_tick('{8'd200, 8'd3, 8'd255, 1'b0});
    while (sb.mode_q != MODE_FWD_CORRECT) offer_tick(sweep_tick(1'b0));

    for (int p = 1; p < 6; p++) begin
      drain();
      load_setup(setups[p]);
      repeat (burst[p]) offer_tick(rand_tick());
    end
    drain();
    repeat (10) @(negedge clk);

    $display("covered %0d tick beats and %0d cmd beats over 6 register setups",
             ticks_taken, sb.checked);
    $display("%0d avoidance sweeps came back to detect", sb.sweeps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("obstacle_avoid_sequencer_tb: PASS");
    end else begin
      $display("obstacle_avoid_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
